// ===== rtl/jacobi_row_update_assert.svh =====
// assertion macros for the jacobi row update block
// used by the modules that carry concurrent checks; expects clk and rst_n in scope
`ifndef JACOBI_ROW_UPDATE_ASSERT_SVH
`define JACOBI_ROW_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define JRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JRU_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JRU_ASSERT(lbl, prop, msg)
`define JRU_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// ===== rtl/jru_pkg.sv =====
// shared types and constants for the jacobi row update block
// no dependencies
package jru_pkg;

    // accumulator and dividend width, q32.32 sum
    localparam int ACC_W = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_INDEX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RHS_VALUE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_THRESHOLD = 2'd2;

    // result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIAG_SMALL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT        = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_NUM,
        S_DIV,
        S_SAT,
        S_DONE
    } jru_state_t;

    typedef struct packed {
        logic load;
        logic acc_en;
        logic clear;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/jru_mac.sv =====
// multiply-accumulate unit: registered product and wrapping q32.32 sum
// depends on jru_pkg
module jru_mac #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jru_pkg::mac_ctrl_t           ctrl,
    input  logic signed [VALUE_WIDTH-1:0] elem,
    input  logic signed [VALUE_WIDTH-1:0] xval,
    output logic [jru_pkg::ACC_W-1:0]    sum
);
    import jru_pkg::*;

    localparam int PROD_W = (2 * VALUE_WIDTH > ACC_W) ? 2 * VALUE_WIDTH : ACC_W;

    logic signed [2*VALUE_WIDTH-1:0] prod_full;
    logic signed [PROD_W-1:0]        prod_ext;
    logic [ACC_W-1:0]                prod_reg;
    logic [ACC_W-1:0]                sum_reg;
    logic [ACC_W-1:0]                sum_next;

    assign prod_full = elem * xval;
    assign prod_ext  = PROD_W'(prod_full);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_ext[ACC_W-1:0];
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            sum_next = sum_reg + prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/jru_divider.sv =====
// restoring divider, one quotient bit per cycle, unsigned
// depends on jru_pkg
module jru_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [jru_pkg::ACC_W-1:0]  dividend,
    input  logic [VALUE_WIDTH-1:0]     divisor,
    output jru_pkg::div_stat_t         stat,
    output logic [jru_pkg::ACC_W-1:0]  quotient
);
    import jru_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] dvs_reg;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic [ACC_W-1:0]       quo_next;

    // shift next dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ACC_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
        quo_next = {quo_reg[ACC_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ACC_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/jacobi_row_update.sv =====
// jacobi row update: after the last element of its row the result passes S_NUM, the bit-serial
// divider in S_DIV, then S_SAT and S_DONE, or goes from S_NUM to S_DONE when the diagonal is too small
// each non-last element is accepted, then S_ACC adds its product to the sum unless it is the diagonal
// a last element holds off the next item until S_DONE can pass the result on; the
// result waits in its own output register so the next row may start before it is taken
// rst_n is asynchronous active low: clears registers to row 0, rhs 0, threshold 1, empty row
module jacobi_row_update #(
    parameter int MAX_N       = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_wen,
    input  logic [jru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]   cfg_data,
    // row element items
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // fields from bit 0: column, matrix_element, current_x, zero pad
    input  logic [((($clog2(MAX_N) + 2 * VALUE_WIDTH) + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                     s_axis_tlast,   // last_element
    // result items
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // fields from bit 0: new_x, zero pad
    output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
    output logic [jru_pkg::STATUS_W-1:0] m_axis_tuser  // status
);
    import jru_pkg::*;

`include "jacobi_row_update_assert.svh"

    localparam int IDX_W      = $clog2(MAX_N);
    localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam logic [ACC_W-1:0] VAL_SIGN = ACC_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [ACC_W-1:0] VAL_MAX  = VAL_SIGN - ACC_W'(1);

    // configuration registers
    logic [IDX_W-1:0]         row_index_reg;
    logic [VALUE_WIDTH-1:0]   rhs_reg;
    logic [VALUE_WIDTH-2:0]   thr_reg;

    // row state
    jru_state_t               state_reg;
    jru_state_t               state_next;
    logic [VALUE_WIDTH-1:0]   diag_reg;
    logic                     seen_reg;
    logic                     is_diag_reg;
    logic                     last_reg;
    logic                     qneg_reg;
    logic [VALUE_WIDTH-1:0]   res_x_reg;
    logic [STATUS_W-1:0]      res_status_reg;

    // output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [VALUE_WIDTH-1:0]   out_x_reg;
    logic [STATUS_W-1:0]      out_status_reg;

    // input fields
    logic [IDX_W-1:0]         in_column;
    logic [VALUE_WIDTH-1:0]   in_elem;
    logic [VALUE_WIDTH-1:0]   in_x;
    logic                     in_accept;

    // control from the sequencer
    mac_ctrl_t                mac_ctrl;
    logic                     div_start;
    logic                     row_clear;
    logic                     res_small_load;
    logic                     res_sat_load;
    logic                     out_free;
    logic                     out_load;

    // datapath
    logic [ACC_W-1:0]         mac_sum;
    div_stat_t                div_stat;
    logic [ACC_W-1:0]         div_quo;
    logic [ACC_W-1:0]         rhs_q;
    logic [ACC_W:0]           diff_rs;
    logic [ACC_W:0]           diff_sr;
    logic                     num_neg;
    logic [ACC_W-1:0]         num_mag;
    logic [VALUE_WIDTH-1:0]   dmag;
    logic                     too_small;
    logic [ACC_W-1:0]         quo_neg;
    logic [VALUE_WIDTH-1:0]   sat_x;
    logic [STATUS_W-1:0]      sat_status;

    assign in_column = s_axis_tdata[IDX_W-1:0];
    assign in_elem   = s_axis_tdata[IDX_W +: VALUE_WIDTH];
    assign in_x      = s_axis_tdata[IDX_W + VALUE_WIDTH +: VALUE_WIDTH];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // configuration writes, taken any cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg <= '0;
            rhs_reg       <= '0;
            thr_reg       <= (VALUE_WIDTH-1)'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ROW_INDEX:      row_index_reg <= cfg_data[IDX_W-1:0];
                REG_RHS_VALUE:      rhs_reg       <= cfg_data;
                REG_DIAG_THRESHOLD: thr_reg       <= cfg_data[VALUE_WIDTH-2:0];
                default:            ;
            endcase
        end
    end

    // product and running off-diagonal sum
    jru_mac #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .elem  ($signed(in_elem)),
        .xval  ($signed(in_x)),
        .sum   (mac_sum)
    );

    // numerator: rhs moved to q32.32 minus the sum, both orders in parallel for the magnitude
    assign rhs_q   = ACC_W'($signed(rhs_reg)) << FRAC_BITS;
    assign diff_rs = {rhs_q[ACC_W-1], rhs_q} - {mac_sum[ACC_W-1], mac_sum};
    assign diff_sr = {mac_sum[ACC_W-1], mac_sum} - {rhs_q[ACC_W-1], rhs_q};
    assign num_neg = diff_rs[ACC_W];
    assign num_mag = num_neg ? diff_sr[ACC_W-1:0] : diff_rs[ACC_W-1:0];

    // diagonal magnitude and the too-small check, a missing diagonal counts as too small
    assign dmag      = diag_reg[VALUE_WIDTH-1] ? ('0 - diag_reg) : diag_reg;
    assign too_small = !seen_reg || (dmag == '0) || (dmag < VALUE_WIDTH'(thr_reg));

    jru_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (dmag),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // apply the sign and clamp to the value range
    always_comb
    begin
        quo_neg    = '0 - div_quo;
        sat_status = STATUS_OK;
        if (qneg_reg)
        begin
            if (div_quo > VAL_SIGN)
            begin
                sat_x      = VAL_SIGN[VALUE_WIDTH-1:0];
                sat_status = STATUS_SAT;
            end
            else
            begin
                sat_x = quo_neg[VALUE_WIDTH-1:0];
            end
        end
        else
        begin
            if (div_quo > VAL_MAX)
            begin
                sat_x      = VAL_MAX[VALUE_WIDTH-1:0];
                sat_status = STATUS_SAT;
            end
            else
            begin
                sat_x = div_quo[VALUE_WIDTH-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:  state_next = last_reg ? S_NUM : S_IDLE;
            S_NUM:  state_next = too_small ? S_DONE : S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready   = 1'b0;
        mac_ctrl        = '0;
        div_start       = 1'b0;
        row_clear       = 1'b0;
        res_small_load  = 1'b0;
        res_sat_load    = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                mac_ctrl.load = s_axis_tvalid;
            end
            S_ACC:
            begin
                mac_ctrl.acc_en = !is_diag_reg;
            end
            S_NUM:
            begin
                // divider latches numerator and divisor, so the row can clear now
                row_clear      = 1'b1;
                mac_ctrl.clear = 1'b1;
                div_start      = !too_small;
                res_small_load = too_small;
            end
            S_DIV:  ;
            S_SAT:
            begin
                res_sat_load = 1'b1;
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            diag_reg    <= '0;
            seen_reg    <= 1'b0;
            is_diag_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                is_diag_reg <= (in_column == row_index_reg);
                last_reg    <= s_axis_tlast;
                // a repeated diagonal replaces the earlier one
                if (in_column == row_index_reg)
                begin
                    diag_reg <= in_elem;
                    seen_reg <= 1'b1;
                end
            end
            else if (row_clear)
            begin
                diag_reg <= '0;
                seen_reg <= 1'b0;
            end
        end
    end

    // pending result, payload only
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            qneg_reg <= num_neg ^ diag_reg[VALUE_WIDTH-1];
        end
        if (res_small_load)
        begin
            res_x_reg      <= '0;
            res_status_reg <= STATUS_DIAG_SMALL;
        end
        else if (res_sat_load)
        begin
            res_x_reg      <= sat_x;
            res_status_reg <= sat_status;
        end
        if (out_load)
        begin
            out_x_reg      <= res_x_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_x_reg);
    assign m_axis_tuser  = out_status_reg;

    // checks
    `JRU_ASSERT(a_div_nonzero, div_start |-> (dmag != '0), "divider started with zero divisor")
    `JRU_ASSERT_ANY(a_done_in_div, div_stat.done |-> (state_reg == S_DIV), "stray divider done")
    `JRU_ASSERT(a_div_running, (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done), "idle div")
    `JRU_ASSERT(a_row_cleared, (state_reg == S_NUM) |=> (!seen_reg && (mac_sum == '0)), "no clear")
    `JRU_ASSERT(a_status_code, out_valid_reg |-> (out_status_reg <= STATUS_SAT), "bad status code")
    `JRU_ASSERT(a_small_zero, out_valid_reg && (out_status_reg == STATUS_DIAG_SMALL) |-> out_x_reg == '0, "x")

endmodule

// ===== tb/jacobi_row_update_tb.sv =====
// self-checking testbench for jacobi_row_update: directed rows, then random rows and settings
// depends on jru_pkg and the jacobi_row_update rtl, nothing else
`timescale 1ns / 1ps

module jacobi_row_update_tb;
    import jru_pkg::*;

    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int FRAC      = 16;
    localparam int S_DATA_W  = (((IDX_W + 2 * VAL_W) + 7) / 8) * 8;
    localparam int M_DATA_W  = ((VAL_W + 7) / 8) * 8;
    // cycles to let the bit-serial divide finish after the last result, with margin
    localparam int DRAIN     = ACC_W + 8;
    // cycles without any handshake or register write before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    localparam int RANDOM_ELEMENTS = 900;

    typedef enum bit {OP_CFG, OP_ELEM} op_kind_t;

    typedef struct packed {
        logic [VAL_W-1:0]    new_x;
        logic [STATUS_W-1:0] status;
    } solution_t;

    // one row of the stimulus table: a register write or one row element
    typedef struct {
        op_kind_t             kind;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [VAL_W-1:0]     value;
        logic [IDX_W-1:0]     col;
        logic [VAL_W-1:0]     a;
        logic [VAL_W-1:0]     x;
        bit                   last;
        bit                   typed;
        solution_t            want;
    } row_op_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wen;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [VAL_W-1:0]         cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [S_DATA_W-1:0]      s_axis_tdata;
    logic                     s_axis_tlast;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [M_DATA_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]      m_axis_tuser;

    jacobi_row_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // column, matrix_element, current_x, zero pad
        .s_axis_tlast  (s_axis_tlast),    // last_element
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // new_x
        .m_axis_tuser  (m_axis_tuser)     // status
    );

    // predictor copy of the registers and the row state
    logic [IDX_W-1:0]  cur_row;
    logic [VAL_W-1:0]  cur_rhs;
    logic [VAL_W-2:0]  cur_thr;
    logic [ACC_W-1:0]  acc_sum;
    logic [VAL_W-1:0]  diag_val;
    bit                diag_seen;

    solution_t pending_solutions[$];

    int  errors;
    int  elements_sent;
    int  results_seen;
    int  cfg_writes;
    int  n_ok;
    int  n_small;
    int  n_sat;
    bit  tx_burst;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: one element in, a solution out when it closes the row
    // ------------------------------------------------------------------
    function automatic bit absorb_element(input logic [IDX_W-1:0] col,
                                          input logic [VAL_W-1:0] a,
                                          input logic [VAL_W-1:0] x,
                                          input bit last,
                                          output solution_t sol);
        logic signed [ACC_W-1:0] prod;
        logic [ACC_W:0]          numer;
        logic [ACC_W:0]          nmag;
        logic [ACC_W:0]          quo;
        logic [ACC_W:0]          negq;
        logic [VAL_W:0]          dmag;
        bit                      nneg;
        bit                      dneg;
        sol.new_x  = '0;
        sol.status = STATUS_OK;
        if (col == cur_row)
        begin
            // a repeated diagonal simply replaces the earlier one
            diag_val  = a;
            diag_seen = 1'b1;
        end
        else
        begin
            prod    = $signed(a) * $signed(x);
            acc_sum = acc_sum + prod;    // wraps modulo 2^64
        end
        if (!last)
            return 1'b0;

        dneg = diag_val[VAL_W-1];
        dmag = dneg ? ({(VAL_W+1){1'b0}} - {1'b1, diag_val}) : {1'b0, diag_val};
        if (!diag_seen || dmag == 0 || dmag < {2'b00, cur_thr})
        begin
            sol.status = STATUS_DIAG_SMALL;
        end
        else
        begin
            // rhs moved to q32.32, difference kept exact with one extra sign bit
            numer = {{(ACC_W + 1 - VAL_W - FRAC){cur_rhs[VAL_W-1]}}, cur_rhs, {FRAC{1'b0}}}
                    - {acc_sum[ACC_W-1], acc_sum};
            nneg = numer[ACC_W];
            nmag = nneg ? ({(ACC_W+1){1'b0}} - numer) : numer;
            quo  = nmag / {{(ACC_W - VAL_W){1'b0}}, dmag};
            if (nneg ^ dneg)
            begin
                if (quo > {1'b0, {(ACC_W - VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}})
                begin
                    sol.new_x  = {1'b1, {(VAL_W-1){1'b0}}};
                    sol.status = STATUS_SAT;
                end
                else
                begin
                    negq      = {(ACC_W+1){1'b0}} - quo;
                    sol.new_x = negq[VAL_W-1:0];
                end
            end
            else if (quo > {{(ACC_W + 2 - VAL_W){1'b0}}, {(VAL_W-1){1'b1}}})
            begin
                sol.new_x  = {1'b0, {(VAL_W-1){1'b1}}};
                sol.status = STATUS_SAT;
            end
            else
            begin
                sol.new_x = quo[VAL_W-1:0];
            end
        end
        acc_sum   = '0;
        diag_val  = '0;
        diag_seen = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic row_op_t elem(input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] a,
                                     input logic [VAL_W-1:0] x, input bit last);
        row_op_t op;
        op.kind    = OP_ELEM;
        op.reg_sel = REG_ROW_INDEX;
        op.value   = '0;
        op.col     = col;
        op.a       = a;
        op.x       = x;
        op.last    = last;
        op.typed   = 1'b0;
        op.want    = '0;
        return op;
    endfunction

    // single-element row whose result is obvious from the fields alone
    function automatic row_op_t elem_known(input logic [IDX_W-1:0] col,
                                           input logic [VAL_W-1:0] a,
                                           input logic [VAL_W-1:0] x,
                                           input logic [VAL_W-1:0] want_x,
                                           input logic [STATUS_W-1:0] want_status);
        row_op_t op;
        op              = elem(col, a, x, 1'b1);
        op.typed        = 1'b1;
        op.want.new_x   = want_x;
        op.want.status  = want_status;
        return op;
    endfunction

    function automatic row_op_t cfg(input logic [CFG_IDX_W-1:0] sel,
                                    input logic [VAL_W-1:0] value);
        row_op_t op;
        op         = elem('0, '0, '0, 1'b0);
        op.kind    = OP_CFG;
        op.reg_sel = sel;
        op.value   = value;
        return op;
    endfunction

    // signed value spread over the given number of low bits
    function automatic logic [VAL_W-1:0] rand_q(input int bits);
        logic signed [VAL_W-1:0] r;
        r = $urandom;
        return r >>> (VAL_W - bits);
    endfunction

    // mostly moderate magnitudes, some full-range words and some corner values
    function automatic logic [VAL_W-1:0] rand_value(input int lo_bits, input int hi_bits);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    4: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            1, 2: return $urandom;
            default: return rand_q($urandom_range(lo_bits, hi_bits));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers: inputs move at the falling edge, handshakes are seen at the rising edge
    // ------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [VAL_W-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        case (sel)
            REG_ROW_INDEX:      cur_row = value[IDX_W-1:0];
            REG_RHS_VALUE:      cur_rhs = value;
            REG_DIAG_THRESHOLD: cur_thr = value[VAL_W-2:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // hold the sender until every solution is back and the divider has gone quiet
    task automatic settle_block;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic send_element(input row_op_t op);
        int        gap;
        solution_t sol;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - IDX_W - 2 * VAL_W){1'b0}}, op.x, op.a, op.col};
        s_axis_tlast  <= op.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        elements_sent++;
        if (absorb_element(op.col, op.a, op.x, op.last, sol))
            pending_solutions.push_back(op.typed ? op.want : sol);
    endtask

    // one random row: mostly well formed, some noise, missing or repeated diagonals
    task automatic run_random_row;
        int      n;
        int      r;
        int      style;
        int      diag_pos;
        row_op_t op;
        style = $urandom_range(0, 9);
        r     = $urandom_range(0, 19);
        n     = (r < 14) ? $urandom_range(1, 6) : (r < 19) ? $urandom_range(7, 16)
                                                         : $urandom_range(17, 64);
        diag_pos = $urandom_range(0, n - 1);
        tx_burst = ($urandom_range(0, 6) == 0);
        for (int k = 0; k < n; k++)
        begin
            op = elem('0, '0, '0, k == n - 1);
            if (style == 0)
            begin
                op.col = $urandom;
                op.a   = $urandom;
                op.x   = $urandom;
            end
            else if ((k == diag_pos && style != 1) || (style == 2 && k == 0))
            begin
                op.col = cur_row;
                op.a   = rand_value(17, 30);
                op.x   = $urandom;
            end
            else
            begin
                op.col = cur_row + IDX_W'($urandom_range(1, (1 << IDX_W) - 1));
                op.a   = rand_value(8, 24);
                op.x   = rand_value(8, 26);
            end
            send_element(op);
        end
    endtask

    task automatic random_settings;
        logic [VAL_W-1:0] thr;
        settle_block();
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 2))
                0: write_register(REG_ROW_INDEX, $urandom);
                1: write_register(REG_RHS_VALUE, rand_value(16, 30));
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: thr = '0;
                        1: thr = 32'h7FFF_FFFF | ($urandom << (VAL_W - 1));
                        2: thr = $urandom;
                        default: thr = $urandom_range(0, 32'h0002_0000);
                    endcase
                    write_register(REG_DIAG_THRESHOLD, thr);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic flag_error(input string what, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    initial
    begin : result_sink
        int        stall;
        bit        rx_burst;
        solution_t want;
        m_axis_tready = 1'b0;
        rx_burst      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            repeat (stall)
            begin
                m_axis_tready <= 1'b0;
                @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            results_seen++;
            if (pending_solutions.size() == 0)
            begin
                flag_error("unexpected result, new_x", '0, m_axis_tdata[VAL_W-1:0]);
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== want.new_x)
                    flag_error("new_x", want.new_x, m_axis_tdata[VAL_W-1:0]);
                if (m_axis_tuser !== want.status)
                    flag_error("status", VAL_W'(want.status), VAL_W'(m_axis_tuser));
                case (want.status)
                    STATUS_DIAG_SMALL: n_small++;
                    STATUS_SAT:        n_sat++;
                    default:           n_ok++;
                endcase
            end
        end
    end

    // watchdog: any handshake or register write counts as progress
    initial
    begin : hang_watch
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
        $display("jacobi_row_update regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        row_op_t plan[$];
        bit      prev_cfg;
        int      directed_count;

        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = REG_ROW_INDEX;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        errors        = 0;
        elements_sent = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        n_ok          = 0;
        n_small       = 0;
        n_sat         = 0;
        tx_burst      = 1'b0;

        // predictor starts from the reset settings: row 0, rhs 0, threshold 1
        cur_row   = '0;
        cur_rhs   = '0;
        cur_thr   = (VAL_W-1)'(1);
        acc_sum   = '0;
        diag_val  = '0;
        diag_seen = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no diagonal at all after reset
        plan.push_back(elem_known(6'd5, 32'h0001_0000, 32'h0001_0000, '0, STATUS_DIAG_SMALL));
        // diagonal only, rhs zero; x of the diagonal is ignored
        plan.push_back(elem_known(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, '0, STATUS_OK));
        plan.push_back(cfg(REG_RHS_VALUE, 32'h0002_0000));
        plan.push_back(elem_known(6'd0, 32'h0001_0000, 32'h0, 32'h0002_0000, STATUS_OK));
        // zero diagonal, with the default threshold and with threshold zero
        plan.push_back(elem_known(6'd0, 32'h0, 32'h0, '0, STATUS_DIAG_SMALL));
        plan.push_back(cfg(REG_DIAG_THRESHOLD, 32'h0));
        plan.push_back(elem_known(6'd0, 32'h0, 32'h8000_0000, '0, STATUS_DIAG_SMALL));
        // largest threshold: only the two largest magnitudes pass
        plan.push_back(cfg(REG_DIAG_THRESHOLD, 32'h7FFF_FFFF));
        plan.push_back(elem(6'd0, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1));
        plan.push_back(elem(6'd0, 32'h8000_0000, 32'h8765_4321, 1'b1));
        plan.push_back(elem_known(6'd0, 32'h7FFF_FFFE, 32'h0, '0, STATUS_DIAG_SMALL));
        // tiny diagonal against the largest rhs saturates both ways
        plan.push_back(cfg(REG_DIAG_THRESHOLD, 32'h1));
        plan.push_back(cfg(REG_RHS_VALUE, 32'h7FFF_FFFF));
        plan.push_back(elem_known(6'd0, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, STATUS_SAT));
        plan.push_back(elem_known(6'd0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, STATUS_SAT));
        // top row; four largest products wrap the accumulator back to zero
        plan.push_back(cfg(REG_ROW_INDEX, 32'd63));
        for (int c = 0; c < 4; c++)
            plan.push_back(elem(IDX_W'(c), 32'h8000_0000, 32'h8000_0000, 1'b0));
        plan.push_back(elem(6'd63, 32'h0001_0000, 32'h0, 1'b1));
        // most negative rhs, repeated diagonal, last element off the diagonal
        plan.push_back(cfg(REG_RHS_VALUE, 32'h8000_0000));
        plan.push_back(elem(6'd63, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(elem(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        plan.push_back(elem(6'd63, 32'h0002_0000, 32'h0, 1'b0));
        plan.push_back(elem(6'd62, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1));

        prev_cfg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == OP_CFG)
            begin
                if (!prev_cfg)
                    settle_block();
                write_register(plan[i].reg_sel, plan[i].value);
                prev_cfg = 1'b1;
            end
            else
            begin
                send_element(plan[i]);
                prev_cfg = 1'b0;
            end
        end
        directed_count = elements_sent;

        // random rows; settings change now and then, always with the block drained
        while (elements_sent < directed_count + RANDOM_ELEMENTS)
        begin
            if ($urandom_range(0, 9) < 3)
                random_settings();
            run_random_row();
        end

        settle_block();
        errors += pending_solutions.size();

        $display("covered %0d row elements and %0d register writes across many row settings",
                 elements_sent, cfg_writes);
        $display("results: %0d total, %0d ok, %0d small diagonal, %0d saturated",
                 results_seen, n_ok, n_small, n_sat);
        if (errors == 0)
            $display("jacobi_row_update regression: pass");
        else
            $display("jacobi_row_update regression: fail");
        $finish;
    end

endmodule

// ===== jacobi_row_update.f =====
+incdir+rtl
rtl/jru_pkg.sv
rtl/jru_mac.sv
rtl/jru_divider.sv
rtl/jacobi_row_update.sv
tb/jacobi_row_update_tb.sv
